/* hdl/text_mode_cell_row_renderer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the text mode cell row renderer
// Shorthand for clocked immediate-implication and next-cycle checks.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CELL_ROW_RENDERER_ASSERT_SVH
`define TEXT_MODE_CELL_ROW_RENDERER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMCR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmcr check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TMCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmcr check failed in the next cycle");

`endif

/* hdl/tmcr_pkg.sv */
// ----------------------------------------------------------------------------
// tmcr_pkg
// Widths, codes, reset values, pipeline stage types and the color palette.
// ----------------------------------------------------------------------------
package tmcr_pkg;

    // Fixed glyph geometry.
    localparam int GLYPH_COLUMNS = 8;
    localparam int GLYPHS        = 256;

    // Defaults for the top-level parameters.
    localparam int CELLS_DEFAULT      = 2048;
    localparam int GLYPH_ROWS_DEFAULT = 16;

    // Field widths.
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int CELL_W   = 11;
    localparam int ROW_W    = 4;
    localparam int BITS_W   = GLYPH_COLUMNS;
    localparam int COLOR_W  = 24;
    localparam int CROW_W   = 5;
    localparam int IDX_W    = 4;

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_W   = 3;

    localparam logic [REG_W-1:0] REG_DISPLAY_ENABLE   = 3'd0;
    localparam logic [REG_W-1:0] REG_BLINK_ENABLE     = 3'd1;
    localparam logic [REG_W-1:0] REG_CURSOR_POSITION  = 3'd2;
    localparam logic [REG_W-1:0] REG_CURSOR_FIRST_ROW = 3'd3;
    localparam logic [REG_W-1:0] REG_CURSOR_LAST_ROW  = 3'd4;
    localparam logic [REG_W-1:0] REG_CURSOR_OFF       = 3'd5;
    localparam logic [REG_W-1:0] REG_SELECTION_BEGIN  = 3'd6;
    localparam logic [REG_W-1:0] REG_SELECTION_FINISH = 3'd7;

    localparam logic              DISPLAY_ENABLE_RST   = 1'b1;
    localparam logic              BLINK_ENABLE_RST     = 1'b0;
    localparam logic [CELL_W-1:0] CURSOR_POSITION_RST  = 11'd0;
    localparam logic [CROW_W-1:0] CURSOR_FIRST_ROW_RST = 5'd14;
    localparam logic [CROW_W-1:0] CURSOR_LAST_ROW_RST  = 5'd15;
    localparam logic              CURSOR_OFF_RST       = 1'b0;
    localparam logic [CELL_W-1:0] SELECTION_RST        = 11'd0;

    // Item modes.
    localparam logic MODE_RENDER = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    localparam logic [COLOR_W-1:0] RGB_WHITE = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] RGB_BLACK = 24'h000000;

    // Stage 1: decoded flags and color indexes, glyph read in flight.
    typedef struct packed {
        logic              zero;
        logic              cursor;
        logic              row_ok;
        logic              ge_begin;
        logic              ge_finish;
        logic [IDX_W-1:0]  fg_idx;
        logic [IDX_W-1:0]  bg_idx;
        logic [CELL_W-1:0] cell_pos;
        logic [ROW_W-1:0]  row;
    } st1_t;

    // Stage 2: final color indexes and the glyph row read from the store.
    typedef struct packed {
        logic              zero;
        logic              cursor;
        logic              row_ok;
        logic [IDX_W-1:0]  fg_idx;
        logic [IDX_W-1:0]  bg_idx;
        logic [BITS_W-1:0] glyph;
        logic [CELL_W-1:0] cell_pos;
        logic [ROW_W-1:0]  row;
    } st2_t;

    // Sixteen-color text palette, RGB 8:8:8.
    function automatic logic [COLOR_W-1:0] palette_color(input logic [IDX_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h000080;
            4'd2:    c = 24'h008000;
            4'd3:    c = 24'h008080;
            4'd4:    c = 24'h800000;
            4'd5:    c = 24'h800080;
            4'd6:    c = 24'hAA5000;
            4'd7:    c = 24'h808080;
            4'd8:    c = 24'h404040;
            4'd9:    c = 24'h0000FF;
            4'd10:   c = 24'h00FF00;
            4'd11:   c = 24'h00FFFF;
            4'd12:   c = 24'hFF0000;
            4'd13:   c = 24'hFF00FF;
            4'd14:   c = 24'hFFFF00;
            4'd15:   c = 24'hFFFFFF;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

endpackage

/* hdl/tmcr_in_if.sv */
// ----------------------------------------------------------------------------
// tmcr_in_if
// Input channel: render or glyph load items with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmcr_in_if import tmcr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [CELL_W-1:0] cell_index;
    logic [ROW_W-1:0]  glyph_row;
    logic              blink_visible;
    logic [BITS_W-1:0] glyph_bits;

    modport source (
        output valid, mode, char_code, attribute, cell_index, glyph_row,
               blink_visible, glyph_bits,
        input  ready
    );

    modport sink (
        input  valid, mode, char_code, attribute, cell_index, glyph_row,
               blink_visible, glyph_bits,
        output ready
    );
endinterface

/* hdl/tmcr_out_if.sv */
// ----------------------------------------------------------------------------
// tmcr_out_if
// Output channel: one rendered cell row with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmcr_out_if import tmcr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BITS_W-1:0]  pixel_bits;
    logic [COLOR_W-1:0] fore_rgb;
    logic [COLOR_W-1:0] back_rgb;
    logic [CELL_W-1:0]  out_cell;
    logic [ROW_W-1:0]   out_row;

    modport source (
        output valid, pixel_bits, fore_rgb, back_rgb, out_cell, out_row,
        input  ready
    );

    modport sink (
        input  valid, pixel_bits, fore_rgb, back_rgb, out_cell, out_row,
        output ready
    );
endinterface

/* hdl/text_mode_cell_row_renderer.sv */
// ----------------------------------------------------------------------------
// text_mode_cell_row_renderer
// Text-mode character generator: glyph store, attribute colors, cursor.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_ch. A load item (mode 1) writes glyph_bits into
// the glyph store at char_code and glyph_row and produces no result. A render
// item (mode 0) produces one transfer on out_ch carrying the glyph row's
// pixel bits, the foreground and background colors and the echoed cell and
// row; a render with a cell index at or above CELLS produces nothing.
// The glyph store must be loaded before a row of it is rendered.
// A render accepted on in_ch passes the stage 1, stage 2 and output registers
// before it is presented on out_ch. Throughput is one item per cycle unless
// out_ch stalls, back to back, loads and renders mixed freely; the single
// store port serves either the write of a load or the read of a render.
// Stalls: while a result waits on out_ch with ready low, the whole pipeline
// holds and in_ch.ready drops; nothing is lost or repeated.
// Reset: rst_n clears all valid bits and sets the registers to their defaults
// (display on, cursor rows 14 to 15). The glyph store is not cleared. The user
// writes configuration over the APB port while the block is idle; not enforced.
// ----------------------------------------------------------------------------
module text_mode_cell_row_renderer import tmcr_pkg::*; #(
    parameter int CELLS      = CELLS_DEFAULT,
    parameter int GLYPH_ROWS = GLYPH_ROWS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    tmcr_in_if.sink            in_ch,
    tmcr_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "text_mode_cell_row_renderer_assert.svh"

    // The glyph store holds GLYPH_ROWS rows for each of the GLYPHS characters.
    localparam int STORE_DEPTH = GLYPHS * GLYPH_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic              display_enable_reg;
    logic              blink_enable_reg;
    logic [CELL_W-1:0] cursor_position_reg;
    logic [CROW_W-1:0] cursor_first_row_reg;
    logic [CROW_W-1:0] cursor_last_row_reg;
    logic              cursor_off_reg;
    logic [CELL_W-1:0] selection_begin_reg;
    logic [CELL_W-1:0] selection_finish_reg;

    logic             cfg_write;
    logic [REG_W-1:0] cfg_sel;

    // Registers sit at word addresses, so the low two address bits are dropped.
    assign pready    = 1'b1;
    assign cfg_sel   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg   <= DISPLAY_ENABLE_RST;
            blink_enable_reg     <= BLINK_ENABLE_RST;
            cursor_position_reg  <= CURSOR_POSITION_RST;
            cursor_first_row_reg <= CURSOR_FIRST_ROW_RST;
            cursor_last_row_reg  <= CURSOR_LAST_ROW_RST;
            cursor_off_reg       <= CURSOR_OFF_RST;
            selection_begin_reg  <= SELECTION_RST;
            selection_finish_reg <= SELECTION_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_DISPLAY_ENABLE:   display_enable_reg   <= pwdata[0];
                REG_BLINK_ENABLE:     blink_enable_reg     <= pwdata[0];
                REG_CURSOR_POSITION:  cursor_position_reg  <= pwdata[CELL_W-1:0];
                REG_CURSOR_FIRST_ROW: cursor_first_row_reg <= pwdata[CROW_W-1:0];
                REG_CURSOR_LAST_ROW:  cursor_last_row_reg  <= pwdata[CROW_W-1:0];
                REG_CURSOR_OFF:       cursor_off_reg       <= pwdata[0];
                REG_SELECTION_BEGIN:  selection_begin_reg  <= pwdata[CELL_W-1:0];
                REG_SELECTION_FINISH: selection_finish_reg <= pwdata[CELL_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_DISPLAY_ENABLE:   prdata = PDATA_W'(display_enable_reg);
            REG_BLINK_ENABLE:     prdata = PDATA_W'(blink_enable_reg);
            REG_CURSOR_POSITION:  prdata = PDATA_W'(cursor_position_reg);
            REG_CURSOR_FIRST_ROW: prdata = PDATA_W'(cursor_first_row_reg);
            REG_CURSOR_LAST_ROW:  prdata = PDATA_W'(cursor_last_row_reg);
            REG_CURSOR_OFF:       prdata = PDATA_W'(cursor_off_reg);
            REG_SELECTION_BEGIN:  prdata = PDATA_W'(selection_begin_reg);
            REG_SELECTION_FINISH: prdata = PDATA_W'(selection_finish_reg);
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Pipeline control. All stages move together; the pipeline only holds
    // when a finished result is waiting on the output and is not taken.
    // ------------------------------------------------------------------------
    logic advance;
    logic out_valid_reg;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = advance;

    // ------------------------------------------------------------------------
    // Stage 0: decode the item, start the glyph store access.
    // ------------------------------------------------------------------------
    logic              in_accept;
    logic              is_load;
    logic              row_ok0;
    logic              cell_ok0;
    logic              hidden0;
    logic              zero0;
    logic              cursor_hit0;
    logic [IDX_W-1:0]  bg_idx0;
    logic [CROW_W-1:0] row_wide0;
    logic [ADDR_W-1:0] store_addr;
    logic              store_en;
    logic [BITS_W-1:0] store_rdata;
    st1_t              st1_next;
    logic              st1_valid_next;

    assign in_accept = in_ch.valid && advance;
    assign is_load   = (in_ch.mode == MODE_LOAD);
    assign row_ok0   = 32'(in_ch.glyph_row) < 32'(GLYPH_ROWS);
    assign cell_ok0  = 32'(in_ch.cell_index) < 32'(CELLS);
    assign row_wide0 = CROW_W'(in_ch.glyph_row);

    // Character-major store layout: each character owns GLYPH_ROWS rows.
    assign store_addr = ADDR_W'(ADDR_W'(in_ch.char_code) * ADDR_W'(GLYPH_ROWS)
                                + ADDR_W'(in_ch.glyph_row));

    // Loads to a row outside the glyph are dropped; renders read only when
    // they will produce a result.
    assign store_en = in_accept && (is_load ? row_ok0 : cell_ok0);

    tmcr_ram #(
        .WIDTH (BITS_W),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_store (
        .clk   (clk),
        .en    (store_en),
        .we    (is_load),
        .addr  (store_addr),
        .wdata (in_ch.glyph_bits),
        .rdata (store_rdata)
    );

    always_comb
    begin
        // In blink mode the top background bit means blink; a blinking cell
        // in its hidden phase is drawn entirely black.
        hidden0 = blink_enable_reg && in_ch.attribute[ATTR_W-1] && !in_ch.blink_visible;
        zero0   = !display_enable_reg || hidden0;
        bg_idx0 = in_ch.attribute[ATTR_W-1:IDX_W];
        if (blink_enable_reg)
        begin
            bg_idx0[IDX_W-1] = 1'b0;
        end

        // The cursor covers an inclusive row range and only in the visible
        // blink phase; an empty range (first after last) shows nothing.
        cursor_hit0 = !zero0 && !cursor_off_reg && in_ch.blink_visible
                      && (in_ch.cell_index == cursor_position_reg)
                      && (row_wide0 >= cursor_first_row_reg)
                      && (row_wide0 <= cursor_last_row_reg);

        st1_valid_next     = in_accept && !is_load && cell_ok0;
        st1_next.zero      = zero0;
        st1_next.cursor    = cursor_hit0;
        st1_next.row_ok    = row_ok0;
        st1_next.ge_begin  = in_ch.cell_index >= selection_begin_reg;
        st1_next.ge_finish = in_ch.cell_index >= selection_finish_reg;
        st1_next.fg_idx    = in_ch.attribute[IDX_W-1:0];
        st1_next.bg_idx    = bg_idx0;
        st1_next.cell_pos  = in_ch.cell_index;
        st1_next.row       = in_ch.glyph_row;
    end

    logic st1_valid_reg;
    st1_t st1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st1_reg <= st1_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: selection test and color inversion; glyph data arrives.
    // ------------------------------------------------------------------------
    logic in_selection1;
    st2_t st2_next;

    always_comb
    begin
        // The selection is half open from the smaller end to the larger one.
        if (selection_begin_reg < selection_finish_reg)
        begin
            in_selection1 = st1_reg.ge_begin && !st1_reg.ge_finish;
        end
        else
        begin
            in_selection1 = st1_reg.ge_finish && !st1_reg.ge_begin;
        end

        st2_next.zero     = st1_reg.zero;
        st2_next.cursor   = st1_reg.cursor;
        st2_next.row_ok   = st1_reg.row_ok;
        // For a four-bit index, 15 minus the index is its complement.
        st2_next.fg_idx   = in_selection1 ? ~st1_reg.fg_idx : st1_reg.fg_idx;
        st2_next.bg_idx   = in_selection1 ? ~st1_reg.bg_idx : st1_reg.bg_idx;
        st2_next.glyph    = store_rdata;
        st2_next.cell_pos = st1_reg.cell_pos;
        st2_next.row      = st1_reg.row;
    end

    logic st2_valid_reg;
    st2_t st2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            st2_valid_reg <= st1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st2_reg <= st2_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: palette lookup and the final overrides into the output register.
    // Blanking and the hidden blink phase win over everything, then the cursor.
    // ------------------------------------------------------------------------
    logic [BITS_W-1:0]  pixel_bits_next;
    logic [COLOR_W-1:0] fore_rgb_next;
    logic [COLOR_W-1:0] back_rgb_next;

    always_comb
    begin
        if (st2_reg.zero)
        begin
            pixel_bits_next = '0;
            fore_rgb_next   = RGB_BLACK;
            back_rgb_next   = RGB_BLACK;
        end
        else if (st2_reg.cursor)
        begin
            pixel_bits_next = '1;
            fore_rgb_next   = RGB_WHITE;
            back_rgb_next   = RGB_WHITE;
        end
        else
        begin
            pixel_bits_next = st2_reg.row_ok ? st2_reg.glyph : '0;
            fore_rgb_next   = palette_color(st2_reg.fg_idx);
            back_rgb_next   = palette_color(st2_reg.bg_idx);
        end
    end

    logic [BITS_W-1:0]  pixel_bits_reg;
    logic [COLOR_W-1:0] fore_rgb_reg;
    logic [COLOR_W-1:0] back_rgb_reg;
    logic [CELL_W-1:0]  out_cell_reg;
    logic [ROW_W-1:0]   out_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pixel_bits_reg <= pixel_bits_next;
            fore_rgb_reg   <= fore_rgb_next;
            back_rgb_reg   <= back_rgb_next;
            out_cell_reg   <= st2_reg.cell_pos;
            out_row_reg    <= st2_reg.row;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_bits = pixel_bits_reg;
    assign out_ch.fore_rgb   = fore_rgb_reg;
    assign out_ch.back_rgb   = back_rgb_reg;
    assign out_ch.out_cell   = out_cell_reg;
    assign out_ch.out_row    = out_row_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `TMCR_ASSERT_SAME(a_stall_blocks_input, out_valid_reg && !out_ch.ready,
                      !in_ch.ready)
    `TMCR_ASSERT_NEXT(a_render_enters_stage1,
                      in_accept && !is_load && cell_ok0, st1_valid_reg)
    `TMCR_ASSERT_NEXT(a_load_makes_no_result, in_accept && is_load, !st1_valid_reg)
    `TMCR_ASSERT_NEXT(a_stage2_reaches_output, advance && st2_valid_reg, out_valid_reg)
    `TMCR_ASSERT_NEXT(a_cursor_row_white,
                      advance && st2_valid_reg && st2_reg.cursor && !st2_reg.zero,
                      pixel_bits_reg == '1 && fore_rgb_reg == RGB_WHITE)

endmodule

/* hdl/tmcr_ram.sv */
// ----------------------------------------------------------------------------
// tmcr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* tb/tb_text_mode_cell_row_renderer.sv */
// ----------------------------------------------------------------------------
// Regression bench for the text mode cell row renderer
// Loads glyph rows, renders cells under a series of screen settings and
// compares every rendered row with a behavioral prediction of the block.
// ----------------------------------------------------------------------------
module tb_text_mode_cell_row_renderer import tmcr_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // Geometry of the block under test; the bench uses the defaults.
    localparam int CELLS      = CELLS_DEFAULT;
    localparam int GLYPH_ROWS = GLYPH_ROWS_DEFAULT;
    localparam int STORE_SIZE = GLYPHS * GLYPH_ROWS;

    // Shape of the run. Each phase programs a new screen setting and then
    // streams random items; the pipeline is three stages deep.
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 240;
    localparam int MAX_IDLE        = 6;
    localparam int LATENCY         = 3;
    localparam int SETTLE_CYCLES   = LATENCY + 4;
    localparam int LONG_HOLD       = 250;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 100;

    // One item on the input channel, either a glyph load or a cell render.
    typedef struct {
        logic              mode;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
        logic [CELL_W-1:0] cell_index;
        logic [ROW_W-1:0]  glyph_row;
        logic              blink_visible;
        logic [BITS_W-1:0] glyph_bits;
    } cell_item_t;

    // One rendered row as it leaves the output channel.
    typedef struct {
        logic [BITS_W-1:0]  pixel_bits;
        logic [COLOR_W-1:0] fore_rgb;
        logic [COLOR_W-1:0] back_rgb;
        logic [CELL_W-1:0]  out_cell;
        logic [ROW_W-1:0]   out_row;
    } cell_row_t;

    // Screen setting as held in the configuration registers.
    typedef struct {
        logic              display_on;
        logic              blink_on;
        logic [CELL_W-1:0] cursor_cell;
        logic [CROW_W-1:0] cursor_top;
        logic [CROW_W-1:0] cursor_bottom;
        logic              cursor_hidden;
        logic [CELL_W-1:0] sel_a;
        logic [CELL_W-1:0] sel_b;
    } screen_cfg_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own glyph store and screen setting, predicts the
    // row each accepted render produces and checks rows in arrival order.
    // ------------------------------------------------------------------------
    class glyph_row_book;
        screen_cfg_t        cfg;
        logic [BITS_W-1:0]  glyph_rows [STORE_SIZE];
        logic [COLOR_W-1:0] palette_rgb [16];
        cell_row_t          pending_rows [$];
        int                 mismatches;

        function new();
            palette_rgb = '{24'h000000, 24'h000080, 24'h008000, 24'h008080,
                            24'h800000, 24'h800080, 24'hAA5000, 24'h808080,
                            24'h404040, 24'h0000FF, 24'h00FF00, 24'h00FFFF,
                            24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF};
            cfg.display_on    = DISPLAY_ENABLE_RST;
            cfg.blink_on      = BLINK_ENABLE_RST;
            cfg.cursor_cell   = CURSOR_POSITION_RST;
            cfg.cursor_top    = CURSOR_FIRST_ROW_RST;
            cfg.cursor_bottom = CURSOR_LAST_ROW_RST;
            cfg.cursor_hidden = CURSOR_OFF_RST;
            cfg.sel_a         = SELECTION_RST;
            cfg.sel_b         = SELECTION_RST;
            mismatches        = 0;
        endfunction

        function void set_reg(logic [REG_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_DISPLAY_ENABLE:   cfg.display_on    = value[0];
                REG_BLINK_ENABLE:     cfg.blink_on      = value[0];
                REG_CURSOR_POSITION:  cfg.cursor_cell   = value[CELL_W-1:0];
                REG_CURSOR_FIRST_ROW: cfg.cursor_top    = value[CROW_W-1:0];
                REG_CURSOR_LAST_ROW:  cfg.cursor_bottom = value[CROW_W-1:0];
                REG_CURSOR_OFF:       cfg.cursor_hidden = value[0];
                REG_SELECTION_BEGIN:  cfg.sel_a         = value[CELL_W-1:0];
                REG_SELECTION_FINISH: cfg.sel_b         = value[CELL_W-1:0];
                default: ;
            endcase
        endfunction

        function int store_addr(logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] row);
            return int'(ch) * GLYPH_ROWS + int'(row);
        endfunction

        function cell_row_t render_row(cell_item_t it);
            cell_row_t         r;
            logic [IDX_W-1:0]  fg_idx;
            logic [IDX_W-1:0]  bg_idx;
            logic [CELL_W-1:0] lo;
            logic [CELL_W-1:0] hi;
            r.pixel_bits = '0;
            r.fore_rgb   = RGB_BLACK;
            r.back_rgb   = RGB_BLACK;
            r.out_cell   = it.cell_index;
            r.out_row    = it.glyph_row;
            fg_idx = it.attribute[3:0];
            bg_idx = it.attribute[7:4];
            // A blanked display and a blinking cell in its dark phase are black.
            if (!cfg.display_on)
                return r;
            if (cfg.blink_on && bg_idx[3] && !it.blink_visible)
                return r;
            if (cfg.blink_on)
                bg_idx[3] = 1'b0;
            lo = (cfg.sel_a < cfg.sel_b) ? cfg.sel_a : cfg.sel_b;
            hi = (cfg.sel_a < cfg.sel_b) ? cfg.sel_b : cfg.sel_a;
            if (it.cell_index >= lo && it.cell_index < hi) begin
                fg_idx = 4'd15 - fg_idx;
                bg_idx = 4'd15 - bg_idx;
            end
            r.fore_rgb = palette_rgb[fg_idx];
            r.back_rgb = palette_rgb[bg_idx];
            if (it.glyph_row < GLYPH_ROWS)
                r.pixel_bits = glyph_rows[store_addr(it.char_code, it.glyph_row)];
            if (it.cell_index == cfg.cursor_cell && it.blink_visible && !cfg.cursor_hidden &&
                {1'b0, it.glyph_row} >= cfg.cursor_top &&
                {1'b0, it.glyph_row} <= cfg.cursor_bottom) begin
                r.pixel_bits = '1;
                r.fore_rgb   = RGB_WHITE;
                r.back_rgb   = RGB_WHITE;
            end
            return r;
        endfunction

        function void take_item(cell_item_t it);
            if (it.mode == MODE_LOAD) begin
                if (it.glyph_row < GLYPH_ROWS)
                    glyph_rows[store_addr(it.char_code, it.glyph_row)] = it.glyph_bits;
            end else if (it.cell_index < CELLS) begin
                pending_rows.push_back(render_row(it));
            end
        endfunction

        task flag_mismatch(string what, logic [31:0] want, logic [31:0] seen);
            if (mismatches < MAX_REPORTS)
                $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want,
                         seen);
            mismatches++;
        endtask

        task check_row(cell_row_t got);
            cell_row_t want;
            if (pending_rows.size() == 0) begin
                flag_mismatch("row with nothing expected (cell)", '0, 32'(got.out_cell));
                return;
            end
            want = pending_rows.pop_front();
            if (got.pixel_bits !== want.pixel_bits)
                flag_mismatch("pixel_bits", 32'(want.pixel_bits), 32'(got.pixel_bits));
            if (got.fore_rgb !== want.fore_rgb)
                flag_mismatch("foreground", 32'(want.fore_rgb), 32'(got.fore_rgb));
            if (got.back_rgb !== want.back_rgb)
                flag_mismatch("background", 32'(want.back_rgb), 32'(got.back_rgb));
            if (got.out_cell !== want.out_cell)
                flag_mismatch("out_cell", 32'(want.out_cell), 32'(got.out_cell));
            if (got.out_row !== want.out_row)
                flag_mismatch("out_row", 32'(want.out_row), 32'(got.out_row));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test and its channels.
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tmcr_in_if  in_ch ();
    tmcr_out_if out_ch ();

    text_mode_cell_row_renderer #(
        .CELLS      (CELLS),
        .GLYPH_ROWS (GLYPH_ROWS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glyph_row_book book;

    // Glyph entries the stimulus has loaded so far. Renders only ever pick
    // from this list, because a glyph row that was never written holds no
    // defined value.
    bit loaded [STORE_SIZE];
    int loaded_list [$];

    // When quiet is set neither side inserts idle cycles, which gives
    // back-to-back stretches. hold_cycles asks the result sink for a long
    // stall; the sink counts it down itself.
    bit quiet;
    int hold_cycles;
    int cycle_count;

    initial begin : clock_gen
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Ends the run with a fail report when cycle_count reaches CYCLE_LIMIT.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("text_mode_cell_row_renderer regression: fail");
        $finish;
    end

    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, MAX_IDLE));
    endfunction

    // ------------------------------------------------------------------------
    // Result sink. All decisions are made at the rising edge: a transfer is
    // recognized from the values before the edge, then the next ready level
    // is set with a single nonblocking assignment.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int        wait_left;
        cell_row_t got;
        out_ch.ready <= 1'b0;
        wait_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.pixel_bits = out_ch.pixel_bits;
                got.fore_rgb   = out_ch.fore_rgb;
                got.back_rgb   = out_ch.back_rgb;
                got.out_cell   = out_ch.out_cell;
                got.out_row    = out_ch.out_row;
                book.check_row(got);
                wait_left = idle_draw();
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task is entered at a rising edge and returns at one.
    // ------------------------------------------------------------------------

    // Register write: a setup phase, then an access phase until pready is seen.
    // The leading edge keeps psel from being lowered and raised in the same
    // time step when writes follow each other.
    task automatic reg_write(input logic [REG_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        book.set_reg(idx, value);
    endtask

    task automatic apply_screen(input screen_cfg_t s);
        reg_write(REG_DISPLAY_ENABLE, PDATA_W'(s.display_on));
        reg_write(REG_BLINK_ENABLE, PDATA_W'(s.blink_on));
        reg_write(REG_CURSOR_POSITION, PDATA_W'(s.cursor_cell));
        reg_write(REG_CURSOR_FIRST_ROW, PDATA_W'(s.cursor_top));
        reg_write(REG_CURSOR_LAST_ROW, PDATA_W'(s.cursor_bottom));
        reg_write(REG_CURSOR_OFF, PDATA_W'(s.cursor_hidden));
        reg_write(REG_SELECTION_BEGIN, PDATA_W'(s.sel_a));
        reg_write(REG_SELECTION_FINISH, PDATA_W'(s.sel_b));
    endtask

    // Offers one item and returns at the edge where it was accepted. valid
    // is only lowered when an idle gap is drawn, so back-to-back items keep
    // it high without a second assignment in the same step.
    task automatic offer_item(input cell_item_t it);
        int gap;
        gap = idle_draw();
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= it.mode;
        in_ch.char_code     <= it.char_code;
        in_ch.attribute     <= it.attribute;
        in_ch.cell_index    <= it.cell_index;
        in_ch.glyph_row     <= it.glyph_row;
        in_ch.blink_visible <= it.blink_visible;
        in_ch.glyph_bits    <= it.glyph_bits;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        book.take_item(it);
    endtask

    // Stops offering and waits until every predicted row has arrived, then
    // lets the pipeline run empty in case a load was the last item.
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (book.pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_row(input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] row,
                            input logic [BITS_W-1:0] bits);
        cell_item_t it;
        int         a;
        it.mode          = MODE_LOAD;
        it.char_code     = ch;
        it.glyph_row     = row;
        it.glyph_bits    = bits;
        // The remaining fields mean nothing on a load; they are random noise.
        it.attribute     = ATTR_W'($urandom);
        it.cell_index    = CELL_W'($urandom);
        it.blink_visible = 1'($urandom);
        a = int'(ch) * GLYPH_ROWS + int'(row);
        if (!loaded[a]) begin
            loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        offer_item(it);
    endtask

    task automatic render_cell(input logic [CHAR_W-1:0] ch, input logic [ROW_W-1:0] row,
                               input logic [ATTR_W-1:0] attr, input logic [CELL_W-1:0] pos,
                               input logic vis);
        cell_item_t it;
        it.mode          = MODE_RENDER;
        it.char_code     = ch;
        it.glyph_row     = row;
        it.attribute     = attr;
        it.cell_index    = pos;
        it.blink_visible = vis;
        it.glyph_bits    = BITS_W'($urandom);
        offer_item(it);
    endtask

    // A random item: about a third are loads, the rest render an entry that
    // is already loaded. Cell positions lean toward the cursor and the
    // selection edges, where the interesting behavior lives.
    task automatic random_item();
        int                a;
        logic [CELL_W-1:0] pos;
        if ($urandom_range(0, 99) < 30 || loaded_list.size() == 0) begin
            load_row(CHAR_W'($urandom), ROW_W'($urandom), BITS_W'($urandom));
        end else begin
            a = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2: pos = book.cfg.cursor_cell;
                3:       pos = book.cfg.sel_a;
                4:       pos = book.cfg.sel_b;
                5:       pos = book.cfg.sel_a - 1'b1;
                6:       pos = book.cfg.sel_b - 1'b1;
                default: pos = CELL_W'($urandom);
            endcase
            render_cell(CHAR_W'(a / GLYPH_ROWS), ROW_W'(a % GLYPH_ROWS), ATTR_W'($urandom),
                        pos, $urandom_range(0, 3) != 0);
        end
    endtask

    // Screen setting for each random phase. The first five phases pin chosen
    // registers, several to their extremes; the later ones are fully random.
    function automatic screen_cfg_t phase_screen(input int p);
        screen_cfg_t s;
        s.display_on    = ($urandom_range(0, 7) != 0);
        s.blink_on      = 1'($urandom);
        s.cursor_cell   = CELL_W'($urandom);
        s.cursor_top    = CROW_W'($urandom_range(0, 15));
        s.cursor_bottom = CROW_W'($urandom_range(int'(s.cursor_top), 31));
        s.cursor_hidden = ($urandom_range(0, 3) == 0);
        s.sel_a         = CELL_W'($urandom);
        s.sel_b         = CELL_W'($urandom);
        case (p)
            0: begin
                // Blanked display: every rendered row comes out black.
                s.display_on = 1'b0;
            end
            1: begin
                // Blink mode with a cursor range wider than the glyph.
                s.display_on    = 1'b1;
                s.blink_on      = 1'b1;
                s.cursor_top    = '0;
                s.cursor_bottom = '1;
                s.cursor_hidden = 1'b0;
                s.sel_a         = '0;
                s.sel_b         = '0;
            end
            2: begin
                // Empty cursor range at the last cell; selection reversed and
                // covering everything but the last cell.
                s.display_on    = 1'b1;
                s.blink_on      = 1'b0;
                s.cursor_cell   = '1;
                s.cursor_top    = '1;
                s.cursor_bottom = '0;
                s.cursor_hidden = 1'b0;
                s.sel_a         = '1;
                s.sel_b         = '0;
            end
            3: begin
                // Cursor switched off; single-row range.
                s.display_on    = 1'b1;
                s.blink_on      = 1'b1;
                s.cursor_top    = '0;
                s.cursor_bottom = '0;
                s.cursor_hidden = 1'b1;
            end
            4: begin
                s.display_on    = 1'b1;
                s.blink_on      = 1'b0;
                s.cursor_cell   = '0;
                s.cursor_top    = 5'd15;
                s.cursor_bottom = '1;
                s.cursor_hidden = 1'b0;
                s.sel_a         = '0;
                s.sel_b         = '1;
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        book        = new();
        quiet       = 1'b0;
        hold_cycles = 0;

        // Every input of the block is known from time zero.
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.mode          <= MODE_RENDER;
        in_ch.char_code     <= '0;
        in_ch.attribute     <= '0;
        in_ch.cell_index    <= '0;
        in_ch.glyph_row     <= '0;
        in_ch.blink_visible <= 1'b0;
        in_ch.glyph_bits    <= '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset setting: display on, no blink mode,
        // cursor on cell 0 rows 14 to 15, empty selection.
        load_row(8'h00, 4'd0, 8'h00);
        load_row(8'h00, 4'd14, 8'h81);
        load_row(8'h00, 4'd15, 8'h7E);
        load_row(8'hFF, 4'd15, 8'hFF);
        load_row(8'hFF, 4'd0, 8'h01);
        load_row(8'h55, 4'd5, 8'hA5);
        load_row(8'hAA, 4'd10, 8'h5A);
        load_row(8'h80, 4'd1, 8'h80);
        // Cursor cell, but the row lies outside the cursor range.
        render_cell(8'h00, 4'd0, 8'h00, 11'd0, 1'b1);
        // First and last cursor rows turn solid white.
        render_cell(8'h00, 4'd14, 8'h07, 11'd0, 1'b1);
        render_cell(8'h00, 4'd15, 8'h4C, 11'd0, 1'b1);
        // The cursor is not drawn in the dark blink phase.
        render_cell(8'h00, 4'd15, 8'hF0, 11'd0, 1'b0);
        render_cell(8'hFF, 4'd15, 8'hFF, 11'd2047, 1'b1);
        // Bright background stays bright while blink mode is off.
        render_cell(8'hFF, 4'd0, 8'h8F, 11'd2047, 1'b0);
        render_cell(8'h55, 4'd5, 8'h1E, 11'd1024, 1'b1);
        render_cell(8'hAA, 4'd10, 8'hE1, 11'd1, 1'b1);
        render_cell(8'h80, 4'd1, 8'h70, 11'd0, 1'b1);
        render_cell(8'hFF, 4'd15, 8'h00, 11'd0, 1'b1);
        // Overwrite a glyph row and read it straight back.
        load_row(8'h00, 4'd0, 8'hC3);
        render_cell(8'h00, 4'd0, 8'h2A, 11'd5, 1'b1);
        wait_for_drain();

        for (int p = 0; p < PHASES; p++) begin
            apply_screen(phase_screen(p));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 60 == 0)
                    quiet = ($urandom_range(0, 2) == 0);
                // Long stall on the output while items keep coming, so the
                // pipeline fills and pushes back on the input.
                if (p == 1 && n == 80)
                    hold_cycles = LONG_HOLD;
                // Let the block run completely dry in the middle of a phase.
                if (p == 3 && n == 120)
                    wait_for_drain();
                random_item();
            end
            wait_for_drain();
        end

        if (book.mismatches == 0)
            $display("text_mode_cell_row_renderer regression: pass");
        else
            $display("text_mode_cell_row_renderer regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/tmcr_pkg.sv
hdl/tmcr_in_if.sv
hdl/tmcr_out_if.sv
hdl/tmcr_ram.sv
hdl/text_mode_cell_row_renderer.sv
tb/tb_text_mode_cell_row_renderer.sv
